[rtl/core/rsd_pkg.sv]
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types, constants and helpers for the RLE sprite tile decoder.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int BYTE_W = 8;
    localparam int SIZE_W = 16;
    localparam int CNT_W  = 17;
    localparam int ADDR_W = 26;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam int HDR_BYTES = 4;
    localparam int PIX_BYTES = 3;

    localparam logic [BYTE_W-1:0] COLOR_FULL   = 8'hFF;
    localparam logic [BYTE_W-1:0] COLOR_NONE   = 8'h00;
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [BYTE_W-1:0] ALPHA_CLEAR  = 8'h00;

    typedef enum logic [8:0] {
        PH_IDLE    = 9'b000000001,
        PH_SIZE_HI = 9'b000000010,
        PH_SKIP_LO = 9'b000000100,
        PH_SKIP_HI = 9'b000001000,
        PH_CNT_LO  = 9'b000010000,
        PH_CNT_HI  = 9'b000100000,
        PH_RED     = 9'b001000000,
        PH_GREEN   = 9'b010000000,
        PH_BLUE    = 9'b100000000
    } phase_t;

    // Result of one parsed byte
    typedef struct packed {
        logic              emit;
        logic              pix_ok;
        logic              sprite_end;
        logic              overrun;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
    } rsd_step_t;

    // Load strobes from the parser to the address generator
    typedef struct packed {
        logic tile_load;
        logic quot_load;
        logic rem_load;
    } rsd_addr_ctl_t;

    function automatic logic [CNT_W-1:0] sat_add(
        input logic [CNT_W-1:0] a,
        input logic [CNT_W-1:0] b
    );
        logic [CNT_W:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            if (sum > {1'b0, CNT_MAX})
            begin
                return CNT_MAX;
            end
            return sum[CNT_W-1:0];
        end
    endfunction

endpackage

[rtl/core/rle_sprite_tile_decoder_core.sv]
// ----------------------------------------------------------------------------
// rle_sprite_tile_decoder_core
// Run-length sprite record decoder with magenta color key and tile addressing.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one record byte per request, with
// first_byte marking the low size byte and tile_row/tile_col sampled on it.
// Output channel (out_valid/out_ready) carries at most one result per byte:
// a pixel write on each blue byte (or an overrun flag when the pixel index is
// past the tile) and a sprite_end-only result when a record closes without a
// pixel. Unused result fields read as zero.
// Throughput is one byte per cycle unless out_ready stalls the output; a byte
// passes the input register, then its result the result register.
// The parser state, pitch and tile origin update in a single pass; the one
// line-times-pitch multiplier sits in front of the result register.
// When out_ready is low the result register holds and the input register
// absorbs one more byte; in_ready then drops until the result is taken.
// tiles_across is written through cfg_wr_en/cfg_wr_data by the user, only while
// idle; the block does not enforce it. Reset (rst_n low, asynchronous) empties
// both registers, returns the parser to idle and sets tiles_across to 1.
// ----------------------------------------------------------------------------
module rle_sprite_tile_decoder_core #(
    parameter int TILE_EDGE = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [rsd_pkg::BYTE_W-1:0]   cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rsd_pkg::BYTE_W-1:0]   data_byte,
    input  logic                         first_byte,
    input  logic [rsd_pkg::BYTE_W-1:0]   tile_row,
    input  logic [rsd_pkg::BYTE_W-1:0]   tile_col,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         pixel_valid,
    output logic [rsd_pkg::ADDR_W-1:0]   pixel_address,
    output logic [rsd_pkg::BYTE_W-1:0]   red,
    output logic [rsd_pkg::BYTE_W-1:0]   green,
    output logic [rsd_pkg::BYTE_W-1:0]   blue,
    output logic [rsd_pkg::BYTE_W-1:0]   alpha,
    output logic                         sprite_end,
    output logic                         overrun
);

    logic                       s1_valid_reg, s1_valid_next;
    logic [rsd_pkg::BYTE_W-1:0] s1_byte_reg;
    logic                       s1_first_reg;
    logic [rsd_pkg::BYTE_W-1:0] s1_row_reg;
    logic [rsd_pkg::BYTE_W-1:0] s1_col_reg;

    logic                       out_valid_reg, out_valid_next;
    logic                       pix_valid_reg;
    logic [rsd_pkg::ADDR_W-1:0] addr_reg;
    logic [rsd_pkg::BYTE_W-1:0] red_reg;
    logic [rsd_pkg::BYTE_W-1:0] green_reg;
    logic [rsd_pkg::BYTE_W-1:0] blue_reg;
    logic [rsd_pkg::BYTE_W-1:0] alpha_reg;
    logic                       end_reg;
    logic                       overrun_reg;

    logic                       in_take;
    logic                       out_free;
    logic                       fire;
    rsd_pkg::rsd_step_t         step;
    rsd_pkg::rsd_addr_ctl_t     ctl;
    logic [rsd_pkg::CNT_W-1:0]  pix_index;
    logic [rsd_pkg::ADDR_W-1:0] pix_addr;

    assign out_free = !out_valid_reg || out_ready;
    assign fire     = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_take  = in_valid && in_ready;

    rsd_parser #(
        .TILE_EDGE (TILE_EDGE)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .data_byte   (s1_byte_reg),
        .first_byte  (s1_first_reg),
        .step        (step),
        .ctl         (ctl),
        .pixel_index (pix_index)
    );

    rsd_addr_gen #(
        .TILE_EDGE (TILE_EDGE)
    ) u_addr_gen (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .ctl           (ctl),
        .tile_row      (s1_row_reg),
        .tile_col      (s1_col_reg),
        .pixel_index   (pix_index),
        .pixel_address (pix_addr)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire && step.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg  <= data_byte;
            s1_first_reg <= first_byte;
            s1_row_reg   <= tile_row;
            s1_col_reg   <= tile_col;
        end
        if (fire && step.emit)
        begin
            pix_valid_reg <= step.pix_ok;
            addr_reg      <= step.pix_ok ? pix_addr : '0;
            red_reg       <= step.red;
            green_reg     <= step.green;
            blue_reg      <= step.blue;
            alpha_reg     <= step.alpha;
            end_reg       <= step.sprite_end;
            overrun_reg   <= step.overrun;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_valid   = pix_valid_reg;
    assign pixel_address = addr_reg;
    assign red           = red_reg;
    assign green         = green_reg;
    assign blue          = blue_reg;
    assign alpha         = alpha_reg;
    assign sprite_end    = end_reg;
    assign overrun       = overrun_reg;

    // a pixel write and an overrun never share a result
    a_pix_xor_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(pixel_valid && overrun))
        else $error("pixel write and overrun on the same result");

    // a result with neither pixel nor overrun can only close a record
    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pixel_valid && !overrun |-> sprite_end)
        else $error("empty result without sprite_end");

    // no pixel means zeroed address and color fields
    a_empty_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pixel_valid |-> pixel_address == '0 && red == '0 &&
            green == '0 && blue == '0 && alpha == '0)
        else $error("nonzero fields on result without pixel");

    // transparent alpha only for the magenta key
    a_key_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_valid && alpha != rsd_pkg::ALPHA_OPAQUE |->
            alpha == rsd_pkg::ALPHA_CLEAR && red == rsd_pkg::COLOR_FULL &&
            green == rsd_pkg::COLOR_NONE && blue == rsd_pkg::COLOR_FULL)
        else $error("alpha does not follow the color key");

    // a byte waiting in the input register is not overwritten
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !fire |=> s1_valid_reg && $stable(s1_byte_reg) &&
            $stable(s1_first_reg))
        else $error("input register lost a waiting byte");

endmodule

[rtl/core/rsd_parser.sv]
// ----------------------------------------------------------------------------
// rsd_parser
// Byte parser: record size, run headers, RGB triples, counters, color key.
// ----------------------------------------------------------------------------
module rsd_parser #(
    parameter int TILE_EDGE = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic [rsd_pkg::BYTE_W-1:0]   data_byte,
    input  logic                         first_byte,
    output rsd_pkg::rsd_step_t           step,
    output rsd_pkg::rsd_addr_ctl_t       ctl,
    output logic [rsd_pkg::CNT_W-1:0]    pixel_index
);

    localparam logic [rsd_pkg::CNT_W-1:0] TILE_PIXELS =
        rsd_pkg::CNT_W'(TILE_EDGE * TILE_EDGE);

    rsd_pkg::phase_t                  phase_reg, phase_next;
    logic [rsd_pkg::SIZE_W-1:0]       size_reg, size_next;
    logic [rsd_pkg::CNT_W-1:0]        bytes_reg, bytes_next;
    logic [rsd_pkg::CNT_W-1:0]        pix_reg, pix_next;
    logic [rsd_pkg::SIZE_W-1:0]       run_reg, run_next;
    logic [rsd_pkg::BYTE_W-1:0]       low_reg, low_next;
    logic [rsd_pkg::BYTE_W-1:0]       red_reg, red_next;
    logic [rsd_pkg::BYTE_W-1:0]       green_reg, green_next;

    logic [rsd_pkg::SIZE_W-1:0]       word;
    logic                             magenta;

    assign word        = {data_byte, low_reg};
    assign pixel_index = pix_reg;
    assign magenta     = (red_reg == rsd_pkg::COLOR_FULL) &&
                         (green_reg == rsd_pkg::COLOR_NONE) &&
                         (data_byte == rsd_pkg::COLOR_FULL);

    always_comb
    begin
        phase_next = phase_reg;
        size_next  = size_reg;
        bytes_next = bytes_reg;
        pix_next   = pix_reg;
        run_next   = run_reg;
        low_next   = low_reg;
        red_next   = red_reg;
        green_next = green_reg;
        step       = '0;
        ctl        = '0;

        if (fire)
        begin
            if (first_byte)
            begin
                // restart: any record in progress is dropped silently
                ctl.tile_load = 1'b1;
                low_next      = data_byte;
                phase_next    = rsd_pkg::PH_SIZE_HI;
            end
            else
            begin
                case (phase_reg)
                    rsd_pkg::PH_IDLE:
                    begin
                        phase_next = rsd_pkg::PH_IDLE;
                    end
                    rsd_pkg::PH_SIZE_HI:
                    begin
                        size_next  = word;
                        bytes_next = '0;
                        pix_next   = '0;
                        run_next   = '0;
                        if (word == '0)
                        begin
                            step.emit       = 1'b1;
                            step.sprite_end = 1'b1;
                            phase_next      = rsd_pkg::PH_IDLE;
                        end
                        else
                        begin
                            phase_next = rsd_pkg::PH_SKIP_LO;
                        end
                    end
                    rsd_pkg::PH_SKIP_LO:
                    begin
                        low_next   = data_byte;
                        phase_next = rsd_pkg::PH_SKIP_HI;
                    end
                    rsd_pkg::PH_SKIP_HI:
                    begin
                        pix_next   = rsd_pkg::sat_add(pix_reg, {1'b0, word});
                        phase_next = rsd_pkg::PH_CNT_LO;
                    end
                    rsd_pkg::PH_CNT_LO:
                    begin
                        low_next   = data_byte;
                        phase_next = rsd_pkg::PH_CNT_HI;
                    end
                    rsd_pkg::PH_CNT_HI:
                    begin
                        run_next   = word;
                        bytes_next = rsd_pkg::sat_add(bytes_reg,
                                                      rsd_pkg::CNT_W'(rsd_pkg::HDR_BYTES));
                        if (word != '0)
                        begin
                            phase_next = rsd_pkg::PH_RED;
                        end
                        else if (bytes_next >= {1'b0, size_reg})
                        begin
                            step.emit       = 1'b1;
                            step.sprite_end = 1'b1;
                            phase_next      = rsd_pkg::PH_IDLE;
                        end
                        else
                        begin
                            phase_next = rsd_pkg::PH_SKIP_LO;
                        end
                    end
                    rsd_pkg::PH_RED:
                    begin
                        red_next      = data_byte;
                        ctl.quot_load = 1'b1;
                        phase_next    = rsd_pkg::PH_GREEN;
                    end
                    rsd_pkg::PH_GREEN:
                    begin
                        green_next   = data_byte;
                        ctl.rem_load = 1'b1;
                        phase_next   = rsd_pkg::PH_BLUE;
                    end
                    rsd_pkg::PH_BLUE:
                    begin
                        bytes_next = rsd_pkg::sat_add(bytes_reg,
                                                      rsd_pkg::CNT_W'(rsd_pkg::PIX_BYTES));
                        run_next   = run_reg - rsd_pkg::SIZE_W'(1);
                        step.emit  = 1'b1;
                        step.sprite_end = (run_next == '0) &&
                                          (bytes_next >= {1'b0, size_reg});
                        if (pix_reg < TILE_PIXELS)
                        begin
                            step.pix_ok = 1'b1;
                            step.red    = red_reg;
                            step.green  = green_reg;
                            step.blue   = data_byte;
                            step.alpha  = magenta ? rsd_pkg::ALPHA_CLEAR
                                                  : rsd_pkg::ALPHA_OPAQUE;
                        end
                        else
                        begin
                            step.overrun = 1'b1;
                        end
                        pix_next = rsd_pkg::sat_add(pix_reg, rsd_pkg::CNT_W'(1));
                        if (step.sprite_end)
                        begin
                            phase_next = rsd_pkg::PH_IDLE;
                        end
                        else if (run_next == '0)
                        begin
                            phase_next = rsd_pkg::PH_SKIP_LO;
                        end
                        else
                        begin
                            phase_next = rsd_pkg::PH_RED;
                        end
                    end
                    default:
                    begin
                        phase_next = rsd_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rsd_pkg::PH_IDLE;
            size_reg  <= '0;
            bytes_reg <= '0;
            pix_reg   <= '0;
            run_reg   <= '0;
            low_reg   <= '0;
            red_reg   <= '0;
            green_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            size_reg  <= size_next;
            bytes_reg <= bytes_next;
            pix_reg   <= pix_next;
            run_reg   <= run_next;
            low_reg   <= low_next;
            red_reg   <= red_next;
            green_reg <= green_next;
        end
    end

endmodule

[rtl/core/rsd_addr_gen.sv]
// ----------------------------------------------------------------------------
// rsd_addr_gen
// Framebuffer pixel address: tile origin, row pitch and in-tile position.
// ----------------------------------------------------------------------------
module rsd_addr_gen #(
    parameter int TILE_EDGE = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [rsd_pkg::BYTE_W-1:0]   cfg_wr_data,
    input  rsd_pkg::rsd_addr_ctl_t       ctl,
    input  logic [rsd_pkg::BYTE_W-1:0]   tile_row,
    input  logic [rsd_pkg::BYTE_W-1:0]   tile_col,
    input  logic [rsd_pkg::CNT_W-1:0]    pixel_index,
    output logic [rsd_pkg::ADDR_W-1:0]   pixel_address
);

    localparam int CE     = $clog2(TILE_EDGE);
    localparam int IDX_W  = $clog2(TILE_EDGE * TILE_EDGE);
    localparam int SHIFT  = IDX_W + CE;
    localparam int RECIP  = ((1 << SHIFT) + TILE_EDGE - 1) / TILE_EDGE;
    localparam int RCP_W  = IDX_W + 2;
    localparam int PROD_W = IDX_W + RCP_W;
    localparam int LINE_W = rsd_pkg::BYTE_W + CE;
    localparam int MUL_W  = 2 * LINE_W;
    localparam int WIDE_W = (MUL_W > rsd_pkg::ADDR_W) ? MUL_W : rsd_pkg::ADDR_W;

    logic [LINE_W-1:0] pitch_reg;
    logic [LINE_W-1:0] col_base_reg;
    logic [rsd_pkg::BYTE_W-1:0] row_reg;
    logic [CE-1:0]     quot_reg;
    logic [CE-1:0]     rem_reg;
    logic [LINE_W-1:0] line_reg;

    logic [IDX_W-1:0]  pix_lo;
    logic [PROD_W-1:0] recip_prod;
    logic [IDX_W-1:0]  rem_full;
    logic [MUL_W-1:0]  line_off;
    logic [WIDE_W-1:0] addr_sum;

    assign pix_lo     = pixel_index[IDX_W-1:0];
    // divide by the tile edge with a reciprocal multiply
    assign recip_prod = PROD_W'(pix_lo) * PROD_W'(RECIP);
    assign rem_full   = pix_lo - IDX_W'(quot_reg * TILE_EDGE);

    // one multiplier: image line of this pixel times line pitch
    assign line_off   = MUL_W'(line_reg) * MUL_W'(pitch_reg);
    assign addr_sum   = WIDE_W'(line_off) + WIDE_W'(col_base_reg) + WIDE_W'(rem_reg);
    assign pixel_address = addr_sum[rsd_pkg::ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg <= LINE_W'(TILE_EDGE);
        end
        else if (cfg_wr_en)
        begin
            pitch_reg <= LINE_W'(cfg_wr_data * TILE_EDGE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.tile_load)
        begin
            row_reg      <= tile_row;
            col_base_reg <= LINE_W'(tile_col * TILE_EDGE);
        end
        if (ctl.quot_load)
        begin
            quot_reg <= CE'(recip_prod >> SHIFT);
        end
        if (ctl.rem_load)
        begin
            rem_reg  <= rem_full[CE-1:0];
            line_reg <= LINE_W'(row_reg * TILE_EDGE) + LINE_W'(quot_reg);
        end
    end

endmodule
